### hw/rtl/capture_response_parser_core_defines.svh
`ifndef CAPTURE_RESPONSE_PARSER_CORE_DEFINES_SVH
`define CAPTURE_RESPONSE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capture response parser: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define CRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capture response parser: next-cycle check failed");

`endif

### hw/rtl/crp_pkg.sv
package crp_pkg;

    // One byte moving from the input stage to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } byte_item_t;

    localparam logic [2:0] KIND_COUNT  = 3'd0;
    localparam logic [2:0] KIND_SAMPLE = 3'd1;
    localparam logic [2:0] KIND_STAMP  = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_ERROR  = 3'd4;

    localparam logic [31:0] ERR_BAD_LINE  = 32'd1;
    localparam logic [31:0] ERR_BAD_COUNT = 32'd2;

    localparam logic [1:0] MODE_8BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT = 2'd1;

    localparam logic [7:0] CHAR_CR = 8'h0d;
    localparam logic [7:0] CHAR_LF = 8'h0a;

    localparam logic [4:0] STATUS_LEN = 5'd15;
    localparam logic [4:0] LINE_POS_MAX = 5'd31;

    localparam logic [31:0] MASK_8BIT  = 32'h0000_00ff;
    localparam logic [31:0] MASK_16BIT = 32'h0000_ffff;
    localparam logic [31:0] MASK_24BIT = 32'h00ff_ffff;

    // Expected status line, one character per position.
    function automatic logic [7:0] status_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "A";
            4'd2:    c = "P";
            4'd3:    c = "T";
            4'd4:    c = "U";
            4'd5:    c = "R";
            4'd6:    c = "E";
            4'd7:    c = "_";
            4'd8:    c = "S";
            4'd9:    c = "T";
            4'd10:   c = "A";
            4'd11:   c = "R";
            4'd12:   c = "T";
            4'd13:   c = "E";
            4'd14:   c = "D";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hw/rtl/crp_input_stage.sv
`include "capture_response_parser_core_defines.svh"

module crp_input_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          rx_byte,
    input  logic                take,
    output crp_pkg::byte_item_t item
);

    logic       main_valid_reg, main_valid_next;
    logic [7:0] main_data_reg,  main_data_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [7:0] skid_data_reg,  skid_data_next;
    logic       accept;

    assign in_stall   = skid_valid_reg;
    assign accept     = in_valid && !skid_valid_reg;
    assign item.valid = main_valid_reg;
    assign item.data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || take)
        begin
            // refill main from skid first, else from the port
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = accept;
                if (accept)
                    main_data_next = rx_byte;
            end
        end
        else if (accept)
        begin
            // park the transfer while main holds
            skid_valid_next = 1'b1;
            skid_data_next  = rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    `CRP_ASSERT_NOW(a_skid_implies_main, clk, rst_n, skid_valid_reg, main_valid_reg)
    `CRP_ASSERT_NEXT(a_skid_fills_on_hold, clk, rst_n,
        accept && main_valid_reg && !take, skid_valid_reg && main_valid_reg)
    `CRP_ASSERT_NEXT(a_main_drains, clk, rst_n,
        take && !skid_valid_reg && !accept, !main_valid_reg)

endmodule

### hw/rtl/crp_parser.sv
`include "capture_response_parser_core_defines.svh"

module crp_parser
#(
    parameter int MAX_SAMPLES = 1048576
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  crp_pkg::byte_item_t item,
    output logic                take,
    input  logic [1:0]          sample_mode,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          result_kind,
    output logic [31:0]         result_value,
    output logic                is_last
);

    localparam int CntW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] PH_LINE     = 3'd0;
    localparam logic [2:0] PH_COUNT    = 3'd1;
    localparam logic [2:0] PH_SAMPLES  = 3'd2;
    localparam logic [2:0] PH_STAMPLEN = 3'd3;
    localparam logic [2:0] PH_STAMPS   = 3'd4;

    logic [2:0]      phase_reg,    phase_next;
    logic [4:0]      line_pos_reg, line_pos_next;
    logic            mismatch_reg, mismatch_next;
    logic [31:0]     asm_reg,      asm_next;
    logic [1:0]      idx_reg,      idx_next;
    logic [CntW-1:0] samples_reg,  samples_next;
    logic [7:0]      stamps_reg,   stamps_next;

    logic            out_valid_reg, out_valid_next;
    logic [2:0]      kind_reg;
    logic [31:0]     value_reg;
    logic            last_reg;

    logic            res_valid;
    logic [2:0]      res_kind;
    logic [31:0]     res_value;
    logic            res_last;

    logic [7:0]      b;
    logic [31:0]     asm_new;
    logic [2:0]      idx_plus;
    logic [2:0]      need;
    logic [31:0]     mask;
    logic            word_done;
    logic            sample_done;
    logic [CntW-1:0] samples_dec;
    logic [7:0]      stamps_dec;
    logic            ready;

    assign ready = !(out_valid_reg && out_stall);
    assign take  = item.valid && ready;
    assign b     = item.data;

    assign asm_new     = asm_reg | (32'(b) << {idx_reg, 3'b000});
    assign idx_plus    = {1'b0, idx_reg} + 3'd1;
    assign word_done   = idx_plus >= 3'd4;
    assign sample_done = idx_plus >= need;
    assign samples_dec = samples_reg - CntW'(1);
    assign stamps_dec  = stamps_reg - 8'd1;

    always_comb
    begin
        unique case (sample_mode)
            crp_pkg::MODE_8BIT:
            begin
                need = 3'd1;
                mask = crp_pkg::MASK_8BIT;
            end
            crp_pkg::MODE_16BIT:
            begin
                need = 3'd2;
                mask = crp_pkg::MASK_16BIT;
            end
            default:
            begin
                need = 3'd4;
                mask = crp_pkg::MASK_24BIT;
            end
        endcase
    end

    always_comb
    begin
        phase_next    = phase_reg;
        line_pos_next = line_pos_reg;
        mismatch_next = mismatch_reg;
        asm_next      = asm_reg;
        idx_next      = idx_reg;
        samples_next  = samples_reg;
        stamps_next   = stamps_reg;
        res_valid     = 1'b0;
        res_kind      = crp_pkg::KIND_ERROR;
        res_value     = 32'd0;
        res_last      = 1'b0;

        unique case (phase_reg)
            PH_COUNT:
            begin
                if (word_done)
                begin
                    asm_next  = 32'd0;
                    idx_next  = 2'd0;
                    res_valid = 1'b1;
                    if (asm_new == 32'd0 || asm_new > 32'(MAX_SAMPLES))
                    begin
                        phase_next   = PH_LINE;
                        samples_next = '0;
                        stamps_next  = 8'd0;
                        res_kind     = crp_pkg::KIND_ERROR;
                        res_value    = crp_pkg::ERR_BAD_COUNT;
                        res_last     = 1'b1;
                    end
                    else
                    begin
                        phase_next   = PH_SAMPLES;
                        samples_next = asm_new[CntW-1:0];
                        res_kind     = crp_pkg::KIND_COUNT;
                        res_value    = asm_new;
                    end
                end
                else
                begin
                    asm_next = asm_new;
                    idx_next = idx_plus[1:0];
                end
            end
            PH_SAMPLES:
            begin
                if (sample_done)
                begin
                    asm_next     = 32'd0;
                    idx_next     = 2'd0;
                    samples_next = samples_dec;
                    if (samples_dec == '0)
                        phase_next = PH_STAMPLEN;
                    res_valid = 1'b1;
                    res_kind  = crp_pkg::KIND_SAMPLE;
                    res_value = asm_new & mask;
                end
                else
                begin
                    asm_next = asm_new;
                    idx_next = idx_plus[1:0];
                end
            end
            PH_STAMPLEN:
            begin
                res_valid = 1'b1;
                res_kind  = crp_pkg::KIND_END;
                res_value = 32'(b);
                asm_next  = 32'd0;
                idx_next  = 2'd0;
                if (b > 8'd1)
                begin
                    phase_next  = PH_STAMPS;
                    stamps_next = b;
                end
                else
                begin
                    phase_next   = PH_LINE;
                    samples_next = '0;
                    stamps_next  = 8'd0;
                    res_last     = 1'b1;
                end
            end
            PH_STAMPS:
            begin
                if (word_done)
                begin
                    asm_next    = 32'd0;
                    idx_next    = 2'd0;
                    stamps_next = stamps_dec;
                    res_valid   = 1'b1;
                    res_kind    = crp_pkg::KIND_STAMP;
                    res_value   = asm_new;
                    if (stamps_dec == 8'd0)
                    begin
                        phase_next   = PH_LINE;
                        samples_next = '0;
                        res_last     = 1'b1;
                    end
                end
                else
                begin
                    asm_next = asm_new;
                    idx_next = idx_plus[1:0];
                end
            end
            default:
            begin
                phase_next = PH_LINE;
                if (b == crp_pkg::CHAR_LF)
                begin
                    line_pos_next = 5'd0;
                    mismatch_next = 1'b0;
                    asm_next      = 32'd0;
                    idx_next      = 2'd0;
                    if (!mismatch_reg && line_pos_reg == crp_pkg::STATUS_LEN)
                        phase_next = PH_COUNT;
                    else
                    begin
                        samples_next = '0;
                        stamps_next  = 8'd0;
                        res_valid    = 1'b1;
                        res_kind     = crp_pkg::KIND_ERROR;
                        res_value    = crp_pkg::ERR_BAD_LINE;
                        res_last     = 1'b1;
                    end
                end
                else if (b != crp_pkg::CHAR_CR)
                begin
                    if (line_pos_reg >= crp_pkg::STATUS_LEN
                        || crp_pkg::status_char(line_pos_reg[3:0]) != b)
                        mismatch_next = 1'b1;
                    if (line_pos_reg < crp_pkg::LINE_POS_MAX)
                        line_pos_next = line_pos_reg + 5'd1;
                end
            end
        endcase
    end

    always_comb
    begin
        if (take)
            out_valid_next = res_valid;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LINE;
            line_pos_reg  <= 5'd0;
            mismatch_reg  <= 1'b0;
            asm_reg       <= 32'd0;
            idx_reg       <= 2'd0;
            samples_reg   <= '0;
            stamps_reg    <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg    <= phase_next;
                line_pos_reg <= line_pos_next;
                mismatch_reg <= mismatch_next;
                asm_reg      <= asm_next;
                idx_reg      <= idx_next;
                samples_reg  <= samples_next;
                stamps_reg   <= stamps_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            kind_reg  <= res_kind;
            value_reg <= res_value;
            last_reg  <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign result_value = value_reg;
    assign is_last      = last_reg;

    `CRP_ASSERT_NEXT(a_last_restarts_line, clk, rst_n,
        take && res_valid && res_last, phase_reg == PH_LINE)
    `CRP_ASSERT_NOW(a_samples_nonzero, clk, rst_n,
        phase_reg == PH_SAMPLES, samples_reg != '0)
    `CRP_ASSERT_NOW(a_last_kind, clk, rst_n, res_valid && res_last,
        res_kind == crp_pkg::KIND_END || res_kind == crp_pkg::KIND_STAMP
        || res_kind == crp_pkg::KIND_ERROR)

endmodule

### hw/rtl/capture_response_parser_core.sv
// Path: a byte is held in the input stage's main register, then parsed, and its
// result is captured in the parser's result register that drives the outputs.
// Throughput: one byte per cycle unless a waiting result is stalled by out_stall;
// the parse state updates in a single pass. While a result waits, the two-entry
// input stage takes up to two more bytes, then stalls.
// Reset (rst_n low, asynchronous): parser awaits a status line, sample_mode is 0.
module capture_response_parser_core
#(
    parameter int MAX_SAMPLES = 1048576
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [31:0] result_value,
    output logic        is_last
);

    logic [1:0]          sample_mode_reg;
    crp_pkg::byte_item_t item;
    logic                take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_mode_reg <= crp_pkg::MODE_8BIT;
        else if (cfg_valid && cfg_ready)
            sample_mode_reg <= cfg_data;
    end

    crp_input_stage u_input
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .take     (take),
        .item     (item)
    );

    crp_parser #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_parser
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .take         (take),
        .sample_mode  (sample_mode_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_value (result_value),
        .is_last      (is_last)
    );

endmodule
